// File: rtl/i2cms_pkg.sv
// Package for the I2C master message sequencer.
// Holds item codes, action and status codes and the decision record.
// No dependencies.
package i2cms_pkg;

	// Default depth of the message data buffer.
	localparam int BUF_DEPTH_DEF = 256;

	// Item function codes.
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_EVENT = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	// Actions handed to the bus shifter.
	localparam logic [2:0] ACT_NONE         = 3'd0;
	localparam logic [2:0] ACT_START_TX     = 3'd1;
	localparam logic [2:0] ACT_START_RX     = 3'd2;
	localparam logic [2:0] ACT_RESUME_ACK   = 3'd3;
	localparam logic [2:0] ACT_RESUME_NOACK = 3'd4;
	localparam logic [2:0] ACT_STOP_TX      = 3'd5;
	localparam logic [2:0] ACT_STOP_RX      = 3'd6;

	// Message status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BUSY  = 2'd1;
	localparam logic [1:0] ST_NOACK = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// Decision taken for one item, before the buffer read data is merged in.
	typedef struct packed {
		logic [2:0] action;
		logic [1:0] status;
		logic [7:0] bus_byte;
		logic       active;
		logic       bus_from_buf;
		logic       read_from_buf;
	} decision_t;

endpackage

// File: rtl/i2cms_item_if.sv
// Input channel of the I2C master message sequencer: handshake and item fields.
// No dependencies.
interface i2cms_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] buffer_index;
	logic [7:0] write_byte;
	logic [6:0] dev_addr;
	logic [8:0] length;
	logic       to_device;
	logic       bus_busy;
	logic       no_ack;
	logic [7:0] rx_byte;

	modport source (
		output valid, func, buffer_index, write_byte, dev_addr, length,
		to_device, bus_busy, no_ack, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, func, buffer_index, write_byte, dev_addr, length,
		to_device, bus_busy, no_ack, rx_byte,
		output ready
	);
endinterface

// File: rtl/i2cms_result_if.sv
// Output channel of the I2C master message sequencer: handshake and result fields.
// No dependencies.
interface i2cms_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] bus_byte;
	logic [1:0] status;
	logic [7:0] read_byte;
	logic       active;

	modport source (
		output valid, action, bus_byte, status, read_byte, active,
		input  ready
	);
	modport sink (
		input  valid, action, bus_byte, status, read_byte, active,
		output ready
	);
endinterface

// File: rtl/i2cms_buf.sv
// Message data buffer: one write port and one registered read port.
// Depends on nothing but its parameters.
module i2cms_buf #(
	parameter int BUF_DEPTH = 256,
	parameter int AW        = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [BUF_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/i2cms_ctrl.sv
// Message control for the I2C master message sequencer: phase, byte count,
// length and the decision for each item. Uses i2cms_pkg.
module i2cms_ctrl import i2cms_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	parameter int AW        = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [1:0]    func,
	input  logic [7:0]    buffer_index,
	input  logic [7:0]    write_byte,
	input  logic [6:0]    dev_addr,
	input  logic [8:0]    length,
	input  logic          to_device,
	input  logic          bus_busy,
	input  logic          no_ack,
	input  logic [7:0]    rx_byte,
	output decision_t     dec,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic [AW-1:0] mem_raddr
);

	// Position width: wide enough for the byte count and for the depth itself.
	localparam int PW = ($clog2(BUF_DEPTH) + 1 > 11) ? $clog2(BUF_DEPTH) + 1 : 11;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TX   = 2'd1;
	localparam logic [1:0] PH_RX   = 2'd2;

	logic [1:0]    phase_q, phase_d;
	logic [9:0]    byte_count_q, byte_count_d;
	logic [8:0]    message_length_q, message_length_d;
	logic [PW-1:0] cnt_p, len_p, wpos, rpos;
	logic          rpos_ok;

	assign cnt_p   = PW'(byte_count_q);
	assign len_p   = PW'(message_length_q);
	assign rpos_ok = rpos < PW'(BUF_DEPTH);

	// Decision for the item at the input.
	always_comb begin
		phase_d          = phase_q;
		byte_count_d     = byte_count_q;
		message_length_d = message_length_q;
		dec              = '0;
		dec.action       = ACT_NONE;
		dec.status       = ST_OK;
		mem_we           = 1'b0;
		wpos             = PW'(buffer_index);
		rpos             = PW'(buffer_index);
		mem_wdata        = write_byte;

		case (func)
			FUNC_LOAD: begin
				mem_we = wpos < PW'(BUF_DEPTH);
			end
			FUNC_READ: begin
				dec.read_from_buf = rpos_ok;
			end
			FUNC_START: begin
				if (phase_q != PH_IDLE || bus_busy) begin
					dec.status = ST_BUSY;
				end else begin
					message_length_d = length;
					byte_count_d     = '0;
					dec.bus_byte     = {dev_addr, ~to_device};
					if (to_device) begin
						phase_d    = PH_TX;
						dec.action = ACT_START_TX;
					end else begin
						phase_d    = PH_RX;
						dec.action = ACT_START_RX;
					end
				end
			end
			default: begin
				// Byte-complete event; ignored while no message runs.
				if (phase_q != PH_IDLE) begin
					byte_count_d = byte_count_q + 10'd1;
					if (phase_q == PH_TX) begin
						rpos = cnt_p;
						if (no_ack) begin
							dec.action = ACT_STOP_TX;
							dec.status = ST_NOACK;
							phase_d    = PH_IDLE;
						end else if (cnt_p >= len_p) begin
							dec.action = ACT_STOP_TX;
							dec.status = ST_DONE;
							phase_d    = PH_IDLE;
						end else begin
							dec.action       = ACT_RESUME_ACK;
							dec.bus_from_buf = rpos_ok;
						end
					end else if (byte_count_q == '0) begin
						// Address byte of a receive message.
						if (no_ack) begin
							dec.action = ACT_STOP_RX;
							dec.status = ST_NOACK;
							phase_d    = PH_IDLE;
						end else if (message_length_q == '0) begin
							dec.action = ACT_STOP_RX;
							dec.status = ST_DONE;
							phase_d    = PH_IDLE;
						end else if (message_length_q == 9'd1) begin
							dec.action = ACT_RESUME_NOACK;
						end else begin
							dec.action = ACT_RESUME_ACK;
						end
					end else begin
						// Data byte received: store it and pick the acknowledge.
						wpos      = cnt_p - PW'(1);
						mem_wdata = rx_byte;
						mem_we    = wpos < PW'(BUF_DEPTH);
						if (cnt_p >= len_p) begin
							dec.action = ACT_STOP_RX;
							dec.status = ST_DONE;
							phase_d    = PH_IDLE;
						end else if (cnt_p + PW'(1) == len_p) begin
							dec.action = ACT_RESUME_NOACK;
						end else begin
							dec.action = ACT_RESUME_ACK;
						end
					end
				end
			end
		endcase

		dec.active = phase_d != PH_IDLE;
		if (!accept) begin
			mem_we = 1'b0;
		end
	end

	assign mem_waddr = wpos[AW-1:0];
	assign mem_raddr = rpos[AW-1:0];

	// Message state, updated on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			byte_count_q     <= '0;
			message_length_q <= '0;
		end else if (accept) begin
			phase_q          <= phase_d;
			byte_count_q     <= byte_count_d;
			message_length_q <= message_length_d;
		end
	end

endmodule

// File: rtl/i2c_master_message_sequencer_unit.sv
// I2C master message sequencer. One item is taken in every clock cycle unless
// a stalled output has filled the middle stage. Each decision is registered in
// the middle stage beside the buffer's registered read data, and the result then
// in the output register. A stalled output holds the result while one further
// item waits in the middle stage, so the input keeps moving until both are full.
// Uses i2cms_pkg, i2cms_item_if, i2cms_result_if, i2cms_ctrl and i2cms_buf.
module i2c_master_message_sequencer_unit import i2cms_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	i2cms_item_if.sink     item,
	i2cms_result_if.source result
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	decision_t     dec, dec_s1;
	logic          v_s1, v_q, adv_s1, accept;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, rdata;
	logic [2:0]    action_q;
	logic [7:0]    bus_byte_q, read_byte_q;
	logic [1:0]    status_q;
	logic          active_q;

	assign adv_s1     = v_s1 && (!v_q || result.ready);
	assign item.ready = !v_s1 || adv_s1;
	assign accept     = item.valid && item.ready;

	i2cms_ctrl #(.BUF_DEPTH(BUF_DEPTH), .AW(AW)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (item.func),
		.buffer_index (item.buffer_index),
		.write_byte   (item.write_byte),
		.dev_addr     (item.dev_addr),
		.length       (item.length),
		.to_device    (item.to_device),
		.bus_busy     (item.bus_busy),
		.no_ack       (item.no_ack),
		.rx_byte      (item.rx_byte),
		.dec          (dec),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr)
	);

	i2cms_buf #(.BUF_DEPTH(BUF_DEPTH), .AW(AW)) u_buf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// Middle stage: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// Middle stage: decision, alongside the buffer read data.
	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv_s1) begin
			v_q <= 1'b1;
		end else if (result.ready) begin
			v_q <= 1'b0;
		end
	end

	// Output register: result fields with the buffer data merged in.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			action_q    <= dec_s1.action;
			status_q    <= dec_s1.status;
			active_q    <= dec_s1.active;
			bus_byte_q  <= dec_s1.bus_from_buf ? rdata : dec_s1.bus_byte;
			read_byte_q <= dec_s1.read_from_buf ? rdata : 8'd0;
		end
	end

	assign result.valid     = v_q;
	assign result.action    = action_q;
	assign result.bus_byte  = bus_byte_q;
	assign result.status    = status_q;
	assign result.read_byte = read_byte_q;
	assign result.active    = active_q;

endmodule

// File: rtl/i2cms_checker.sv
// Port checker for the I2C master message sequencer, bound to the top level.
// Uses i2cms_pkg.
module i2cms_checker import i2cms_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_action,
	input logic [7:0] res_bus_byte,
	input logic [1:0] res_status,
	input logic       res_active
);

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// A refused start leaves the bus alone.
	a_busy_none: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_BUSY |-> res_action == ACT_NONE)
		else $error("refused start produced an action");

	// A stop ends the message.
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_action == ACT_STOP_TX || res_action == ACT_STOP_RX)
		|-> !res_active)
		else $error("message still active after a stop");

	// A start or resume leaves the message running.
	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_action == ACT_START_TX || res_action == ACT_START_RX ||
		res_action == ACT_RESUME_ACK || res_action == ACT_RESUME_NOACK)
		|-> res_active)
		else $error("message inactive after a start or resume");

	// Nothing is placed on the shifter without an action.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_action == ACT_NONE |-> res_bus_byte == 8'd0)
		else $error("bus byte without an action");

endmodule

bind i2c_master_message_sequencer_unit i2cms_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_action   (result.action),
	.res_bus_byte (result.bus_byte),
	.res_status   (result.status),
	.res_active   (result.active)
);
